/* design/binary_mesh_stream_parser_assert.svh */
// Assertion macros used by the verification checker of the mesh parser.
`ifndef BINARY_MESH_STREAM_PARSER_ASSERT_SVH
`define BINARY_MESH_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmsp assertion failed");

// Next-cycle implication, checked outside reset.
`define BMSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmsp assertion failed");

`endif

/* design/bmsp_pkg.sv */
package bmsp_pkg;

    localparam int SIG_LEN    = 22;
    localparam int FLAG_LAST  = 25;
    localparam int XFORM_LAST = 36;
    localparam int JOINT_MAX  = 512;
    localparam int NAME_BYTES = 64;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'd76, 8'd105, 8'd110, 8'd100, 8'd101, 8'd110, 8'd32, 8'd66, 8'd105, 8'd110, 8'd97,
        8'd114, 8'd121, 8'd32, 8'd77, 8'd101, 8'd115, 8'd104, 8'd32, 8'd49, 8'd46, 8'd48
    };

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_XFORM,
        PH_VCOUNT,
        PH_POS,
        PH_NRM,
        PH_BIN,
        PH_UV,
        PH_DET,
        PH_WGT,
        PH_FCOUNT,
        PH_FACE,
        PH_JCOUNT,
        PH_JNAME,
        PH_TAIL
    } t_phase;

    typedef enum logic [2:0] {
        KIND_POS,
        KIND_NRM,
        KIND_UV,
        KIND_FACE,
        KIND_DONE,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TRUNCATED,
        ST_BAD_HEADER,
        ST_NO_VERTS,
        ST_NO_FACES,
        ST_MANY_JOINTS
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [15:0] element_number;
        t_status     status;
        logic        file_finished;
    } t_result;

    // Up to two results per input byte: an element and the end-of-file result.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] sh, logic [7:0] b);
        logic [31:0] r;
        r = w;
        case (sh)
            2'd0:    r[7:0]   = b;
            2'd1:    r[15:8]  = b;
            2'd2:    r[23:16] = b;
            default: r[31:24] = b;
        endcase
        return r;
    endfunction

endpackage

/* design/bmsp_in_if.sv */
interface bmsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

/* design/bmsp_out_if.sv */
interface bmsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [15:0] element_number;
    logic [2:0]  status;
    logic        file_finished;

    modport source (
        output valid, output kind, output word_a, output word_b, output word_c,
        output element_number, output status, output file_finished, input ready
    );
    modport sink (
        input valid, input kind, input word_a, input word_b, input word_c,
        input element_number, input status, input file_finished, output ready
    );
endinterface

/* design/bmsp_parser.sv */
module bmsp_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_file,
    output bmsp_pkg::t_push o_push
);
    import bmsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_bc, n_bc;
    logic [4:0]  r_hbs, n_hbs;
    logic        r_mismatch, n_mismatch;
    logic        r_weights, n_weights;
    logic        r_detail, n_detail;
    logic [15:0] r_vtotal, n_vtotal;
    logic [15:0] r_ftotal, n_ftotal;
    logic [9:0]  r_jtotal, n_jtotal;
    logic [15:0] r_ec, n_ec;
    logic [9:0]  r_nc, n_nc;
    logic [31:0] r_words [3];
    logic [31:0] n_words [3];
    logic        r_error, n_error;
    t_push       n_push;

    function automatic t_result mk_result(t_kind k, logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [15:0] e, t_status s,
                                          logic f);
        t_result r;
        r.kind           = k;
        r.word_a         = a;
        r.word_b         = b;
        r.word_c         = c;
        r.element_number = e;
        r.status         = s;
        r.file_finished  = f;
        return r;
    endfunction

    always_comb begin
        logic [1:0]  lane;
        logic [1:0]  sh;
        logic        do_gather;
        logic [15:0] cnt;
        logic [15:0] ec_inc;
        logic [15:0] total;
        t_phase      after_sec;
        logic        elem_done;
        logic [9:0]  nc_inc;
        logic        clear_all;

        n_phase    = r_phase;
        n_bc       = r_bc;
        n_hbs      = r_hbs;
        n_mismatch = r_mismatch;
        n_weights  = r_weights;
        n_detail   = r_detail;
        n_vtotal   = r_vtotal;
        n_ftotal   = r_ftotal;
        n_jtotal   = r_jtotal;
        n_ec       = r_ec;
        n_nc       = r_nc;
        n_error    = r_error;
        n_words    = r_words;
        n_push     = '0;
        lane       = 2'd0;
        sh         = 2'd0;
        do_gather  = 1'b0;
        cnt        = '0;
        ec_inc     = r_ec + 16'd1;
        total      = r_vtotal;
        after_sec  = r_phase;
        elem_done  = 1'b0;
        nc_inc     = r_nc + 10'd1;
        clear_all  = 1'b0;

        // Byte placement into the assembly words for the sections that collect data.
        case (r_phase) inside
            PH_VCOUNT, PH_FCOUNT, PH_JCOUNT: begin
                do_gather = 1'b1;
                lane      = 2'd0;
                sh        = r_bc[1:0];
            end
            PH_POS, PH_NRM, PH_UV: begin
                do_gather = 1'b1;
                lane      = r_bc[3:2];
                sh        = r_bc[1:0];
            end
            PH_FACE: begin
                do_gather = 1'b1;
                lane      = r_bc[2:1];
                sh        = {1'b0, r_bc[0]};
            end
            default: begin
                do_gather = 1'b0;
            end
        endcase

        if (i_fire && !r_error && do_gather) begin
            for (int l = 0; l < 3; l++) begin
                if (lane == 2'(l)) begin
                    n_words[l] = put_byte(r_words[l], sh, i_data_byte);
                end
            end
        end
        cnt = n_words[0][15:0];

        if (i_fire) begin
            if (r_error) begin
                clear_all = i_end_of_file;
            end else begin
                unique case (r_phase) inside
                    PH_HEADER: begin
                        if (r_hbs < 5'(SIG_LEN) && i_data_byte != SIG_BYTES[r_hbs]) begin
                            n_mismatch = 1'b1;
                        end
                        if (r_hbs == 5'(FLAG_LAST - 1)) begin
                            n_weights = (i_data_byte != 8'd0);
                        end
                        if (r_hbs >= 5'(FLAG_LAST)) begin
                            n_detail = (i_data_byte != 8'd0);
                            if (n_mismatch) begin
                                n_push.v0 = 1'b1;
                                n_push.r0 = mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                      ST_BAD_HEADER, 1'b1);
                                n_error   = 1'b1;
                            end else begin
                                n_phase = PH_XFORM;
                                n_bc    = '0;
                            end
                        end else begin
                            n_hbs = r_hbs + 5'd1;
                        end
                    end
                    PH_XFORM: begin
                        if (r_bc >= 6'(XFORM_LAST)) begin
                            n_phase = PH_VCOUNT;
                            n_bc    = '0;
                        end else begin
                            n_bc = r_bc + 6'd1;
                        end
                    end
                    PH_VCOUNT, PH_FCOUNT, PH_JCOUNT: begin
                        if (r_bc == 6'd0) begin
                            n_bc = 6'd1;
                        end else begin
                            n_bc = '0;
                            n_ec = '0;
                            if (r_phase == PH_VCOUNT) begin
                                if (cnt == 16'd0) begin
                                    n_push.v0 = 1'b1;
                                    n_push.r0 = mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                          ST_NO_VERTS, 1'b1);
                                    n_error   = 1'b1;
                                end else begin
                                    n_vtotal = cnt;
                                    n_phase  = PH_POS;
                                end
                            end else if (r_phase == PH_FCOUNT) begin
                                if (cnt == 16'd0) begin
                                    n_push.v0 = 1'b1;
                                    n_push.r0 = mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                          ST_NO_FACES, 1'b1);
                                    n_error   = 1'b1;
                                end else begin
                                    n_ftotal = cnt;
                                    n_phase  = PH_FACE;
                                end
                            end else begin
                                if (cnt > 16'(JOINT_MAX)) begin
                                    n_push.v0 = 1'b1;
                                    n_push.r0 = mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                          ST_MANY_JOINTS, 1'b1);
                                    n_error   = 1'b1;
                                end else begin
                                    n_jtotal = cnt[9:0];
                                    n_nc     = '0;
                                    n_phase  = (cnt == 16'd0) ? PH_TAIL : PH_JNAME;
                                end
                            end
                        end
                    end
                    PH_POS, PH_NRM: begin
                        if (r_bc < 6'd11) begin
                            n_bc = r_bc + 6'd1;
                        end else begin
                            n_push.v0 = 1'b1;
                            n_push.r0 = mk_result((r_phase == PH_POS) ? KIND_POS : KIND_NRM,
                                                  n_words[0], n_words[2],
                                                  n_words[1] ^ 32'h8000_0000,
                                                  r_ec, ST_OK, 1'b0);
                            elem_done = 1'b1;
                            after_sec = (r_phase == PH_POS) ? PH_NRM : PH_BIN;
                        end
                    end
                    PH_BIN: begin
                        if (r_bc < 6'd11) begin
                            n_bc = r_bc + 6'd1;
                        end else begin
                            elem_done = 1'b1;
                            after_sec = PH_UV;
                        end
                    end
                    PH_UV: begin
                        if (r_bc < 6'd7) begin
                            n_bc = r_bc + 6'd1;
                        end else begin
                            n_push.v0 = 1'b1;
                            n_push.r0 = mk_result(KIND_UV, n_words[0], n_words[1], '0,
                                                  r_ec, ST_OK, 1'b0);
                            elem_done = 1'b1;
                            after_sec = r_detail ? PH_DET : (r_weights ? PH_WGT : PH_FCOUNT);
                        end
                    end
                    PH_DET: begin
                        if (r_bc < 6'd7) begin
                            n_bc = r_bc + 6'd1;
                        end else begin
                            elem_done = 1'b1;
                            after_sec = r_weights ? PH_WGT : PH_FCOUNT;
                        end
                    end
                    PH_WGT: begin
                        if (r_bc < 6'd3) begin
                            n_bc = r_bc + 6'd1;
                        end else begin
                            elem_done = 1'b1;
                            after_sec = PH_FCOUNT;
                        end
                    end
                    PH_FACE: begin
                        if (r_bc < 6'd5) begin
                            n_bc = r_bc + 6'd1;
                        end else begin
                            n_push.v0 = 1'b1;
                            n_push.r0 = mk_result(KIND_FACE,
                                                  {16'd0, n_words[0][15:0]},
                                                  {16'd0, n_words[1][15:0]},
                                                  {16'd0, n_words[2][15:0]},
                                                  r_ec, ST_OK, 1'b0);
                            elem_done = 1'b1;
                            total     = r_ftotal;
                            after_sec = r_weights ? PH_JCOUNT : PH_TAIL;
                        end
                    end
                    PH_JNAME: begin
                        if (r_bc < 6'(NAME_BYTES - 1)) begin
                            n_bc = r_bc + 6'd1;
                        end else begin
                            n_bc = '0;
                            n_nc = nc_inc;
                            if (nc_inc >= r_jtotal) begin
                                n_phase = PH_TAIL;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase

                // One element finished: count it and leave the section after the last.
                if (elem_done) begin
                    n_bc = '0;
                    if (ec_inc == total) begin
                        n_ec    = '0;
                        n_phase = after_sec;
                    end else begin
                        n_ec = ec_inc;
                    end
                end

                if (i_end_of_file) begin
                    if (!n_error) begin
                        n_push.v1 = 1'b1;
                        if (n_phase == PH_TAIL) begin
                            n_push.r1 = mk_result(KIND_DONE, '0, '0, '0, '0, ST_OK, 1'b1);
                        end else begin
                            n_push.r1 = mk_result(KIND_ERROR, '0, '0, '0, '0,
                                                  ST_TRUNCATED, 1'b1);
                        end
                    end
                    clear_all = 1'b1;
                end
            end
        end

        if (clear_all) begin
            n_phase    = PH_HEADER;
            n_bc       = '0;
            n_hbs      = '0;
            n_mismatch = 1'b0;
            n_weights  = 1'b0;
            n_detail   = 1'b0;
            n_vtotal   = '0;
            n_ftotal   = '0;
            n_jtotal   = '0;
            n_ec       = '0;
            n_nc       = '0;
            n_error    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_bc       <= '0;
            r_hbs      <= '0;
            r_mismatch <= 1'b0;
            r_weights  <= 1'b0;
            r_detail   <= 1'b0;
            r_vtotal   <= '0;
            r_ftotal   <= '0;
            r_jtotal   <= '0;
            r_ec       <= '0;
            r_nc       <= '0;
            r_error    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_bc       <= n_bc;
            r_hbs      <= n_hbs;
            r_mismatch <= n_mismatch;
            r_weights  <= n_weights;
            r_detail   <= n_detail;
            r_vtotal   <= n_vtotal;
            r_ftotal   <= n_ftotal;
            r_jtotal   <= n_jtotal;
            r_ec       <= n_ec;
            r_nc       <= n_nc;
            r_error    <= n_error;
        end
    end

    // The assembly words are always fully rewritten before they are read out.
    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    assign o_push = n_push;

endmodule

/* design/bmsp_out_fifo.sv */
module bmsp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmsp_pkg::t_push   i_push,
    input  logic              i_ready,
    output logic              o_valid,
    output bmsp_pkg::t_result o_data,
    output logic              o_room
);
    import bmsp_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_AW:0]     r_count, n_count;
    logic                 pop;
    logic [1:0]           push_n;
    logic [FIFO_AW-1:0]   wr_next;

    assign pop     = (r_count != '0) && i_ready;
    assign push_n  = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wr_next = r_wr + FIFO_AW'(1);

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(push_n);
        n_rd    = pop ? r_rd + FIFO_AW'(1) : r_rd;
        n_count = r_count + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // A lone end-of-file result takes the first free slot.
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
            if (i_push.v1) begin
                r_mem[wr_next] <= i_push.r1;
            end
        end else if (i_push.v1) begin
            r_mem[r_wr] <= i_push.r1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

endmodule

/* design/binary_mesh_stream_parser.sv */
// Byte-serial parser for a binary avatar mesh file.
// Input channel i_in carries one file byte per request, with end_of_file set
// on the last byte of each file. Output channel o_out carries one result per
// request: positions, normals, texture coordinates and faces in file order,
// then a single done or error result with file_finished set.
// Throughput is one byte per cycle while the output queue has room. A byte is
// handled in the cycle it is accepted; the queue registers its results.
// A byte may produce two results (an element that completes on the last byte
// followed by done or error); both go into a four-entry output queue, and
// i_in.ready is low while fewer than two entries are free.
// After an error the remaining bytes of the file are consumed without output.
// Every end-of-file byte returns the parser to its header state.
// Reset (i_rst_n low, synchronous) empties the output queue and returns the
// parser to its header state. When the receiver stalls, the queue fills and
// input is held off; no result is dropped or repeated.
module binary_mesh_stream_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmsp_in_if.sink    i_in,
    bmsp_out_if.source o_out
);
    import bmsp_pkg::*;

    logic    fire;
    logic    room;
    t_push   push;
    t_result res;

    assign fire = i_in.valid && room;
    assign i_in.ready = room;

    bmsp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_data_byte   (i_in.data_byte),
        .i_end_of_file (i_in.end_of_file),
        .o_push        (push)
    );

    bmsp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (res),
        .o_room  (room)
    );

    assign o_out.kind           = res.kind;
    assign o_out.word_a         = res.word_a;
    assign o_out.word_b         = res.word_b;
    assign o_out.word_c         = res.word_c;
    assign o_out.element_number = res.element_number;
    assign o_out.status         = res.status;
    assign o_out.file_finished  = res.file_finished;

endmodule

/* design/bmsp_checker.sv */
`include "binary_mesh_stream_parser_assert.svh"

module bmsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_kind,
    input logic [2:0] i_status,
    input logic       i_file_finished
);
    import bmsp_pkg::*;

    logic is_last;

    assign is_last = (i_kind == KIND_DONE) || (i_kind == KIND_ERROR);

    // Done and error results, and only those, close a file.
    `BMSP_ASSERT_NOW(a_finish_on_last, i_clk, i_rst_n, i_out_valid && is_last, i_file_finished)
    `BMSP_ASSERT_NOW(a_last_on_finish, i_clk, i_rst_n, i_out_valid && i_file_finished, is_last)
    // Status is nonzero exactly on error results.
    `BMSP_ASSERT_NOW(a_status_error, i_clk, i_rst_n, i_out_valid,
                     (i_kind == KIND_ERROR) == (i_status != ST_OK))
    `BMSP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                      i_out_valid && $stable(i_kind) && $stable(i_status))

endmodule

bind binary_mesh_stream_parser bmsp_checker u_bmsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_kind          (o_out.kind),
    .i_status        (o_out.status),
    .i_file_finished (o_out.file_finished)
);
